[rtl/core/swst_pkg.sv]
// Shared types, sizes and helpers for the sliding window sender tracker.
// No dependencies; every other file of the block imports this package.
`default_nettype none

package swst_pkg;

    // Ring depth and derived widths
    localparam int WINDOW_MAX = 32;
    localparam int SLOT_W     = $clog2(WINDOW_MAX);
    localparam int CNT_W      = $clog2(WINDOW_MAX + 1);

    // Fixed field widths
    localparam int CMD_W      = 2;
    localparam int SEQ_W      = 32;
    localparam int TICK_W     = 32;
    localparam int WSZ_W      = 6;
    localparam int STATUS_W   = 3;
    localparam int SLOT_OUT_W = 5;
    localparam int FREED_W    = 6;
    localparam int IFL_W      = 6;
    localparam int CFG_IDX_W  = 1;
    localparam int CFG_DATA_W = 32;

    localparam logic [WSZ_W-1:0]  WIN_SIZE_RESET = WSZ_W'(20);
    localparam logic [TICK_W-1:0] TIMEOUT_RESET  = TICK_W'(10000);
    localparam logic [CNT_W-1:0]  WIN_MAX_CNT    = CNT_W'(WINDOW_MAX);

    typedef enum logic [CMD_W-1:0] {
        CMD_SEND = 2'd0,
        CMD_ACK  = 2'd1,
        CMD_TICK = 2'd2,
        CMD_NOP  = 2'd3
    } t_cmd;

    typedef enum logic [STATUS_W-1:0] {
        ST_QUEUED       = 3'd0,
        ST_FULL         = 3'd1,
        ST_ACK_IN_ORDER = 3'd2,
        ST_ACK_MARKED   = 3'd3,
        ST_ACK_DROPPED  = 3'd4,
        ST_RESEND       = 3'd5,
        ST_IDLE         = 3'd6
    } t_status;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_WINDOW_SIZE   = 1'd0,
        CFG_TIMEOUT_TICKS = 1'd1
    } t_cfg_idx;

    typedef enum logic [3:0] {
        S_IDLE,
        S_SEND,
        S_ACK_RD,
        S_ACK_CHK,
        S_RELEASE,
        S_TICK,
        S_SCAN,
        S_NOP,
        S_EMIT
    } t_state;

    // Controller to datapath commands
    typedef struct packed {
        logic load_item;
        logic send_exec;
        logic ack_check;
        logic rel_step;
        logic tick_start;
        logic scan_step;
        logic nop_exec;
        logic out_load;
    } t_ctl;

    // Datapath to controller status
    typedef struct packed {
        logic ack_match;
        logic rel_more;
        logic scan_hit;
        logic scan_end;
    } t_sts;

    // Step a ring pointer, wrapping at the effective window size
    function automatic logic [SLOT_W-1:0] next_slot(input logic [SLOT_W-1:0] p,
                                                    input logic [CNT_W-1:0]  w);
        logic [CNT_W-1:0] s;
        s = CNT_W'(p) + CNT_W'(1);
        return (s >= w) ? '0 : s[SLOT_W-1:0];
    endfunction

endpackage

`default_nettype wire

[rtl/core/swst_ctrl.sv]
// Sequencing state machine of the sliding window sender tracker.
// Depends on swst_pkg; drives the datapath through t_ctl and reads t_sts.
`default_nettype none

module swst_ctrl (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_in_valid,
    output logic                        o_in_ready,
    input  logic [swst_pkg::CMD_W-1:0]  i_command,
    output logic                        o_out_valid,
    input  logic                        i_out_ready,
    input  swst_pkg::t_sts              i_sts,
    output swst_pkg::t_ctl              o_ctl
);
    import swst_pkg::*;

    t_state r_state;
    t_state n_state;
    logic   r_out_valid;
    logic   n_out_valid;
    logic   out_free;
    logic   in_take;

    assign out_free    = !r_out_valid || i_out_ready;
    assign in_take     = (r_state == S_IDLE) && i_in_valid;
    assign o_in_ready  = (r_state == S_IDLE);
    assign o_out_valid = r_out_valid;

    // Advance state and output valid
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
        end
    end

    // Next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    unique case (t_cmd'(i_command))
                        CMD_SEND: n_state = S_SEND;
                        CMD_ACK:  n_state = S_ACK_RD;
                        CMD_TICK: n_state = S_TICK;
                        CMD_NOP:  n_state = S_NOP;
                    endcase
                end
            end
            S_SEND:    n_state = S_EMIT;
            S_ACK_RD:  n_state = S_ACK_CHK;
            S_ACK_CHK: n_state = i_sts.ack_match ? S_RELEASE : S_SCAN;
            S_RELEASE: n_state = i_sts.rel_more ? S_RELEASE : S_EMIT;
            S_TICK:    n_state = S_SCAN;
            S_SCAN: begin
                if (i_sts.scan_hit || i_sts.scan_end) begin
                    n_state = S_EMIT;
                end
            end
            S_NOP:     n_state = S_EMIT;
            S_EMIT:    n_state = out_free ? S_IDLE : S_EMIT;
            default:   n_state = S_IDLE;
        endcase
    end

    // Commands to the datapath
    always_comb begin
        o_ctl            = '0;
        o_ctl.load_item  = in_take;
        o_ctl.send_exec  = (r_state == S_SEND);
        o_ctl.ack_check  = (r_state == S_ACK_CHK);
        o_ctl.rel_step   = (r_state == S_RELEASE);
        o_ctl.tick_start = (r_state == S_TICK);
        o_ctl.scan_step  = (r_state == S_SCAN);
        o_ctl.nop_exec   = (r_state == S_NOP);
        o_ctl.out_load   = (r_state == S_EMIT) && out_free;
    end

    // Hold the result valid until it is taken
    always_comb begin
        n_out_valid = r_out_valid;
        if (i_out_ready) begin
            n_out_valid = 1'b0;
        end
        if (o_ctl.out_load) begin
            n_out_valid = 1'b1;
        end
    end

endmodule

`default_nettype wire

[rtl/core/swst_datapath.sv]
// Slot storage, pointers, scan engine and result registers of the tracker.
// Depends on swst_pkg; acts on t_ctl commands and reports t_sts.
`default_nettype none

module swst_datapath (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  swst_pkg::t_ctl                    i_ctl,
    output swst_pkg::t_sts                    o_sts,
    input  logic                              i_cfg_wr,
    input  logic [swst_pkg::CFG_IDX_W-1:0]    i_cfg_index,
    input  logic [swst_pkg::CFG_DATA_W-1:0]   i_cfg_data,
    input  logic [swst_pkg::CMD_W-1:0]        i_command,
    input  logic [swst_pkg::SEQ_W-1:0]        i_new_seq,
    input  logic [swst_pkg::SEQ_W-1:0]        i_ack_num,
    output logic [swst_pkg::STATUS_W-1:0]     o_status,
    output logic [swst_pkg::SLOT_OUT_W-1:0]   o_slot,
    output logic [swst_pkg::SEQ_W-1:0]        o_seq_out,
    output logic [swst_pkg::FREED_W-1:0]      o_freed,
    output logic [swst_pkg::IFL_W-1:0]        o_in_flight
);
    import swst_pkg::*;

    // Configuration
    logic [WSZ_W-1:0]   r_win_size;
    logic [TICK_W-1:0]  r_timeout;

    // Window state
    logic [TICK_W-1:0]     r_now;
    logic [SLOT_W-1:0]     r_send_ptr;
    logic [SLOT_W-1:0]     r_oldest;
    logic [CNT_W-1:0]      r_occ;
    logic [WINDOW_MAX-1:0] r_busy;
    logic [WINDOW_MAX-1:0] r_marked;

    // Latched request
    t_cmd              r_cmd;
    logic [SEQ_W-1:0]  r_nseq;
    logic [SEQ_W-1:0]  r_ack;

    // Walk pointer, step count and compare stage
    logic [SLOT_W-1:0] r_ptr;
    logic [CNT_W-1:0]  r_cnt;
    logic              r_cmp_vld;
    logic [SLOT_W-1:0] r_cmp_ptr;
    logic [CNT_W-1:0]  r_freed;

    // Slot memories
    logic [SEQ_W-1:0]  mem_seq   [WINDOW_MAX];
    logic [TICK_W-1:0] mem_stamp [WINDOW_MAX];
    logic [SEQ_W-1:0]  r_seq_rd;
    logic [TICK_W-1:0] r_stamp_rd;

    // Result and output registers
    t_status           r_res_status;
    logic [SLOT_W-1:0] r_res_slot;
    logic [SEQ_W-1:0]  r_res_seq;
    logic [CNT_W-1:0]  r_res_freed;
    t_status           r_o_status;
    logic [SLOT_W-1:0] r_o_slot;
    logic [SEQ_W-1:0]  r_o_seq;
    logic [CNT_W-1:0]  r_o_freed;
    logic [CNT_W-1:0]  r_o_ifl;

    logic [CNT_W-1:0]  eff_w;
    logic [SLOT_W-1:0] rd_addr;
    logic              is_tick;
    logic              issue_ok;
    logic [TICK_W-1:0] age;
    logic              scan_hit;
    logic              scan_end;
    logic              ack_match;
    logic              rel_more;
    logic              send_ok;
    logic [SLOT_W-1:0] ptr_next;
    logic [SLOT_W-1:0] oldest_next;
    logic [SLOT_W-1:0] send_next;
    logic [CNT_W-1:0]  occ_dec;
    logic              st_we;
    logic [SLOT_W-1:0] st_addr;

    // Clamp the window size to the built depth
    always_comb begin
        if (r_win_size == '0) begin
            eff_w = CNT_W'(1);
        end else if (int'(r_win_size) > WINDOW_MAX) begin
            eff_w = WIN_MAX_CNT;
        end else begin
            eff_w = CNT_W'(r_win_size);
        end
    end

    assign is_tick     = (r_cmd == CMD_TICK);
    assign rd_addr     = i_ctl.scan_step ? r_ptr : r_oldest;
    assign ptr_next    = next_slot(r_ptr, eff_w);
    assign oldest_next = next_slot(r_oldest, eff_w);
    assign send_next   = next_slot(r_send_ptr, eff_w);
    assign occ_dec     = (r_occ != '0) ? r_occ - CNT_W'(1) : r_occ;
    assign age         = r_now - r_stamp_rd;

    // Scan: tick walks 0 to window minus one, ack walks round from oldest
    assign issue_ok = is_tick ? (r_cnt < eff_w)
                              : ((r_cnt < WIN_MAX_CNT) && (r_ptr != r_oldest));
    assign scan_hit = r_cmp_vld && r_busy[r_cmp_ptr] &&
                      (is_tick ? (!r_marked[r_cmp_ptr] && (age > r_timeout))
                               : (r_seq_rd == r_ack));
    assign scan_end = !scan_hit && !issue_ok && !r_cmp_vld;

    assign ack_match = r_busy[r_oldest] && (r_seq_rd == r_ack);
    assign rel_more  = (r_cnt < WIN_MAX_CNT) && r_busy[r_ptr] && r_marked[r_ptr];
    assign send_ok   = (r_occ < eff_w) && !r_busy[r_send_ptr];

    always_comb begin
        o_sts           = '0;
        o_sts.ack_match = ack_match;
        o_sts.rel_more  = rel_more;
        o_sts.scan_hit  = scan_hit;
        o_sts.scan_end  = scan_end;
    end

    // Stamp write port: new send or restamp on resend
    always_comb begin
        st_we   = 1'b0;
        st_addr = r_send_ptr;
        if (i_ctl.send_exec && send_ok) begin
            st_we = 1'b1;
        end else if (i_ctl.scan_step && scan_hit && is_tick) begin
            st_we   = 1'b1;
            st_addr = r_cmp_ptr;
        end
    end

    // Slot memories with registered read
    always_ff @(posedge i_clk) begin
        r_seq_rd   <= mem_seq[rd_addr];
        r_stamp_rd <= mem_stamp[rd_addr];
        if (i_ctl.send_exec && send_ok) begin
            mem_seq[r_send_ptr] <= r_nseq;
        end
        if (st_we) begin
            mem_stamp[st_addr] <= r_now;
        end
    end

    // Latch the request
    always_ff @(posedge i_clk) begin
        if (i_ctl.load_item) begin
            r_cmd  <= t_cmd'(i_command);
            r_nseq <= i_new_seq;
            r_ack  <= i_ack_num;
        end
    end

    // Window state, configuration and walk control
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_win_size <= WIN_SIZE_RESET;
            r_timeout  <= TIMEOUT_RESET;
            r_now      <= '0;
            r_send_ptr <= '0;
            r_oldest   <= '0;
            r_occ      <= '0;
            r_busy     <= '0;
            r_marked   <= '0;
            r_ptr      <= '0;
            r_cnt      <= '0;
            r_cmp_vld  <= 1'b0;
            r_cmp_ptr  <= '0;
            r_freed    <= '0;
        end else begin
            if (i_cfg_wr) begin
                unique case (t_cfg_idx'(i_cfg_index))
                    CFG_WINDOW_SIZE:   r_win_size <= i_cfg_data[WSZ_W-1:0];
                    CFG_TIMEOUT_TICKS: r_timeout  <= i_cfg_data[TICK_W-1:0];
                endcase
            end

            // Queue a new packet
            if (i_ctl.send_exec && send_ok) begin
                r_busy[r_send_ptr]   <= 1'b1;
                r_marked[r_send_ptr] <= 1'b0;
                r_occ                <= r_occ + CNT_W'(1);
                r_send_ptr           <= send_next;
            end

            // Free the oldest slot or start the search ahead
            if (i_ctl.ack_check) begin
                r_ptr     <= oldest_next;
                r_cnt     <= '0;
                r_cmp_vld <= 1'b0;
                if (ack_match) begin
                    r_busy[r_oldest]   <= 1'b0;
                    r_marked[r_oldest] <= 1'b0;
                    r_occ              <= occ_dec;
                    r_freed            <= CNT_W'(1);
                end
            end

            // Release following marked slots, one a cycle
            if (i_ctl.rel_step) begin
                if (rel_more) begin
                    r_busy[r_ptr]   <= 1'b0;
                    r_marked[r_ptr] <= 1'b0;
                    r_occ           <= occ_dec;
                    r_freed         <= r_freed + CNT_W'(1);
                    r_ptr           <= ptr_next;
                    r_cnt           <= r_cnt + CNT_W'(1);
                end else begin
                    r_oldest <= r_ptr;
                end
            end

            // Advance time and start the timeout scan
            if (i_ctl.tick_start) begin
                r_now     <= r_now + TICK_W'(1);
                r_ptr     <= '0;
                r_cnt     <= '0;
                r_cmp_vld <= 1'b0;
            end

            // Issue one read and compare the previous one
            if (i_ctl.scan_step) begin
                r_cmp_vld <= issue_ok;
                r_cmp_ptr <= r_ptr;
                if (issue_ok) begin
                    r_ptr <= is_tick ? r_ptr + SLOT_W'(1) : ptr_next;
                    r_cnt <= r_cnt + CNT_W'(1);
                end
                if (scan_hit && !is_tick) begin
                    r_marked[r_cmp_ptr] <= 1'b1;
                end
            end
        end
    end

    // Build the result
    always_ff @(posedge i_clk) begin
        if (i_ctl.send_exec) begin
            r_res_slot  <= r_send_ptr;
            r_res_freed <= '0;
            if (send_ok) begin
                r_res_status <= ST_QUEUED;
                r_res_seq    <= r_nseq;
            end else begin
                r_res_status <= ST_FULL;
                r_res_seq    <= '0;
            end
        end
        if (i_ctl.rel_step && !rel_more) begin
            r_res_status <= ST_ACK_IN_ORDER;
            r_res_slot   <= r_oldest;
            r_res_seq    <= r_ack;
            r_res_freed  <= r_freed;
        end
        if (i_ctl.scan_step && scan_hit) begin
            r_res_slot  <= r_cmp_ptr;
            r_res_freed <= '0;
            if (is_tick) begin
                r_res_status <= ST_RESEND;
                r_res_seq    <= r_seq_rd;
            end else begin
                r_res_status <= ST_ACK_MARKED;
                r_res_seq    <= r_ack;
            end
        end
        if (i_ctl.scan_step && scan_end) begin
            r_res_freed <= '0;
            if (is_tick) begin
                r_res_status <= ST_IDLE;
                r_res_slot   <= '0;
                r_res_seq    <= '0;
            end else begin
                r_res_status <= ST_ACK_DROPPED;
                r_res_slot   <= r_oldest;
                r_res_seq    <= r_ack;
            end
        end
        if (i_ctl.nop_exec) begin
            r_res_status <= ST_IDLE;
            r_res_slot   <= '0;
            r_res_seq    <= '0;
            r_res_freed  <= '0;
        end
    end

    // Output register
    always_ff @(posedge i_clk) begin
        if (i_ctl.out_load) begin
            r_o_status <= r_res_status;
            r_o_slot   <= r_res_slot;
            r_o_seq    <= r_res_seq;
            r_o_freed  <= r_res_freed;
            r_o_ifl    <= r_occ;
        end
    end

    assign o_status    = r_o_status;
    assign o_slot      = SLOT_OUT_W'(r_o_slot);
    assign o_seq_out   = r_o_seq;
    assign o_freed     = FREED_W'(r_o_freed);
    assign o_in_flight = IFL_W'(r_o_ifl);

endmodule

`default_nettype wire

[rtl/core/sliding_window_sender_tracker.sv]
// Top level of the sliding window sender tracker: controller plus datapath.
// Depends on swst_pkg, swst_ctrl and swst_datapath.
//
// The block keeps the sender side of a selective-repeat window in a ring of
// 32 slots and takes one request at a time, answering each with one result.
// A send passes through the send and emit states before its result is
// registered. An ack that matches the oldest slot passes through read,
// check, release (repeated for each extra slot freed) and emit; an ack
// that searches ahead and a tick walk the slots in the scan state, one
// slot per cycle over the single read port of the slot memories. The
// result sits in an output register, so the next request is accepted while
// a result waits. Configuration writes are always taken; write them only
// while no request is in progress. There is no clearing pass after reset.
`default_nettype none

module sliding_window_sender_tracker (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_in_valid,
    output logic                              o_in_ready,
    input  logic [swst_pkg::CMD_W-1:0]        i_command,
    input  logic [swst_pkg::SEQ_W-1:0]        i_new_seq,
    input  logic [swst_pkg::SEQ_W-1:0]        i_ack_num,
    output logic                              o_out_valid,
    input  logic                              i_out_ready,
    output logic [swst_pkg::STATUS_W-1:0]     o_status,
    output logic [swst_pkg::SLOT_OUT_W-1:0]   o_slot,
    output logic [swst_pkg::SEQ_W-1:0]        o_seq_out,
    output logic [swst_pkg::FREED_W-1:0]      o_freed,
    output logic [swst_pkg::IFL_W-1:0]        o_in_flight,
    input  logic                              i_cfg_valid,
    output logic                              o_cfg_ready,
    input  logic [swst_pkg::CFG_IDX_W-1:0]    i_cfg_index,
    input  logic [swst_pkg::CFG_DATA_W-1:0]   i_cfg_data
);
    import swst_pkg::*;

    t_ctl ctl;
    t_sts sts;

    // Configuration writes never stall
    assign o_cfg_ready = 1'b1;

    swst_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .i_command   (i_command),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .i_sts       (sts),
        .o_ctl       (ctl)
    );

    swst_datapath u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_ctl       (ctl),
        .o_sts       (sts),
        .i_cfg_wr    (i_cfg_valid),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .i_command   (i_command),
        .i_new_seq   (i_new_seq),
        .i_ack_num   (i_ack_num),
        .o_status    (o_status),
        .o_slot      (o_slot),
        .o_seq_out   (o_seq_out),
        .o_freed     (o_freed),
        .o_in_flight (o_in_flight)
    );

endmodule

`default_nettype wire

[rtl/core/swst_checker.sv]
// Port-level checks for the sliding window sender tracker, bound to the top.
// Depends on swst_pkg and sliding_window_sender_tracker.
`default_nettype none

module swst_checker (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_in_valid,
    input  logic                              o_in_ready,
    input  logic                              o_out_valid,
    input  logic                              i_out_ready,
    input  logic [swst_pkg::STATUS_W-1:0]     o_status,
    input  logic [swst_pkg::SLOT_OUT_W-1:0]   o_slot,
    input  logic [swst_pkg::SEQ_W-1:0]        o_seq_out,
    input  logic [swst_pkg::FREED_W-1:0]      o_freed,
    input  logic [swst_pkg::IFL_W-1:0]        o_in_flight
);
    import swst_pkg::*;

    // Hold a stalled result
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !i_out_ready |=>
            o_out_valid && $stable(o_status) && $stable(o_slot) &&
            $stable(o_seq_out) && $stable(o_freed) && $stable(o_in_flight))
        else $error("result changed while stalled");

    // One request in progress at a time
    a_one_req: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && o_in_ready |=> !o_in_ready)
        else $error("request accepted while busy");

    // A queued packet leaves the window occupied and frees nothing
    a_queued: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && (o_status == ST_QUEUED) |->
            (o_freed == '0) && (o_in_flight != '0))
        else $error("queued result inconsistent");

    // An in-order ack frees at least one slot
    a_in_order: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && (o_status == ST_ACK_IN_ORDER) |-> (o_freed != '0))
        else $error("in-order ack freed nothing");

    // Occupancy never exceeds the ring
    a_occ_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> (int'(o_in_flight) <= WINDOW_MAX))
        else $error("in_flight beyond ring depth");

endmodule

bind sliding_window_sender_tracker swst_checker u_swst_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_in_valid  (i_in_valid),
    .o_in_ready  (o_in_ready),
    .o_out_valid (o_out_valid),
    .i_out_ready (i_out_ready),
    .o_status    (o_status),
    .o_slot      (o_slot),
    .o_seq_out   (o_seq_out),
    .o_freed     (o_freed),
    .o_in_flight (o_in_flight)
);

`default_nettype wire
